@@ design/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
// No dependencies; each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every clk edge outside reset.
`define ACP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent and consequent given apart, same-cycle implication.
`define ACP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ design/acp_pkg.sv @@
// Shared types and codes of the ASCII command parser.
// No dependencies; used by acp_step and the top level.
package acp_pkg;

	// parser phase codes
	localparam logic [3:0] PH_HASH  = 4'd0;
	localparam logic [3:0] PH_NRNUM = 4'd1;
	localparam logic [3:0] PH_S     = 4'd2;
	localparam logic [3:0] PH_T     = 4'd3;
	localparam logic [3:0] PH_E     = 4'd4;
	localparam logic [3:0] PH_W     = 4'd5;
	localparam logic [3:0] PH_COL   = 4'd6;
	localparam logic [3:0] PH_VALC  = 4'd7;
	localparam logic [3:0] PH_CHECK = 4'd8;
	localparam logic [3:0] PH_EXC   = 4'd9;

	// command kinds
	localparam logic [1:0] KIND_NEW  = 2'd0;
	localparam logic [1:0] KIND_RST  = 2'd1;
	localparam logic [1:0] KIND_MOVE = 2'd2;
	localparam logic [1:0] KIND_CAND = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_UNREC = 2'd1;
	localparam logic [1:0] ERR_START = 2'd2;
	localparam logic [1:0] ERR_CSUM  = 2'd3;

	// characters
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_EXCL = 8'h21;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_E    = 8'h45;
	localparam logic [7:0] CH_W    = 8'h57;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_9    = 8'h39;

	typedef struct packed {
		logic [3:0] phase;
		logic       game_started;
		logic [4:0] digit_sum;
		logic [3:0] row_digit;
		logic [3:0] col_digit;
		logic [3:0] value_digit;
		logic [1:0] pending_kind;
	} state_t;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_byte;
		logic [1:0] error_code;
		logic       cmd_valid;
		logic [1:0] cmd_kind;
		logic [3:0] cmd_row;
		logic [3:0] cmd_col;
		logic [3:0] cmd_value;
	} result_t;

	localparam state_t STATE_RST = '{
		phase: PH_HASH, game_started: 1'b0, digit_sum: 5'd0, row_digit: 4'd0,
		col_digit: 4'd0, value_digit: 4'd0, pending_kind: KIND_NEW
	};

endpackage

@@ design/acp_step.sv @@
// One parse step: next parser state and result for one received byte.
// Purely combinational; depends on acp_pkg.
module acp_step (
	input  acp_pkg::state_t  st,
	input  logic [7:0]       rx_byte,
	input  logic             busy_req,
	output acp_pkg::state_t  st_nxt,
	output acp_pkg::result_t res
);
	import acp_pkg::*;

	logic       dig19;
	logic       dig09;
	logic [3:0] dig;
	logic [7:0] csum_char;

	assign dig19     = rx_byte inside {[CH_1:CH_9]};
	assign dig09     = rx_byte inside {[CH_0:CH_9]};
	assign dig       = rx_byte[3:0];
	assign csum_char = {5'b00110, st.digit_sum[2:0]};

	always_comb begin
		st_nxt = st;
		res    = '0;
		if (!busy_req) begin
			case (st.phase)
				PH_NRNUM: begin
					if (rx_byte == CH_N) begin
						res.echo_valid      = 1'b1;
						st_nxt.pending_kind = KIND_NEW;
						st_nxt.phase        = PH_E;
					end else if (st.game_started && rx_byte == CH_R) begin
						res.echo_valid      = 1'b1;
						st_nxt.pending_kind = KIND_RST;
						st_nxt.phase        = PH_S;
					end else if (st.game_started && dig19) begin
						res.echo_valid   = 1'b1;
						st_nxt.row_digit = dig;
						st_nxt.digit_sum = st.digit_sum + {1'b0, dig};
						st_nxt.phase     = PH_COL;
					end else begin
						res.error_code = st.game_started ? ERR_UNREC : ERR_START;
						st_nxt.phase   = PH_HASH;
					end
				end
				PH_S: begin
					if (rx_byte == CH_S) begin
						res.echo_valid = 1'b1;
						st_nxt.phase   = PH_T;
					end else begin
						res.error_code = ERR_UNREC;
						st_nxt.phase   = PH_HASH;
					end
				end
				PH_T: begin
					if (rx_byte == CH_T) begin
						res.echo_valid = 1'b1;
						st_nxt.phase   = PH_EXC;
					end else begin
						res.error_code = ERR_UNREC;
						st_nxt.phase   = PH_HASH;
					end
				end
				PH_E: begin
					if (rx_byte == CH_E) begin
						res.echo_valid = 1'b1;
						st_nxt.phase   = PH_W;
					end else begin
						res.error_code = ERR_UNREC;
						st_nxt.phase   = PH_HASH;
					end
				end
				PH_W: begin
					if (rx_byte == CH_W) begin
						res.echo_valid = 1'b1;
						st_nxt.phase   = PH_EXC;
					end else begin
						res.error_code = ERR_UNREC;
						st_nxt.phase   = PH_HASH;
					end
				end
				PH_COL: begin
					if (dig19) begin
						res.echo_valid   = 1'b1;
						st_nxt.col_digit = dig;
						st_nxt.digit_sum = st.digit_sum + {1'b0, dig};
						st_nxt.phase     = PH_VALC;
					end else begin
						res.error_code = ERR_UNREC;
						st_nxt.phase   = PH_HASH;
					end
				end
				PH_VALC: begin
					if (rx_byte == CH_C) begin
						res.echo_valid      = 1'b1;
						st_nxt.pending_kind = KIND_CAND;
						st_nxt.phase        = PH_EXC;
					end else if (dig09) begin
						res.echo_valid     = 1'b1;
						st_nxt.value_digit = dig;
						st_nxt.digit_sum   = st.digit_sum + {1'b0, dig};
						st_nxt.phase       = PH_CHECK;
					end else begin
						res.error_code = ERR_UNREC;
						st_nxt.phase   = PH_HASH;
					end
				end
				PH_CHECK: begin
					// checksum digit is the running sum mod 8
					if (rx_byte == csum_char) begin
						res.echo_valid      = 1'b1;
						st_nxt.pending_kind = KIND_MOVE;
						st_nxt.phase        = PH_EXC;
					end else begin
						res.error_code = ERR_CSUM;
						st_nxt.phase   = PH_HASH;
					end
				end
				PH_EXC: begin
					// anything but '!' drops the command silently
					if (rx_byte == CH_EXCL) begin
						res.echo_valid = 1'b1;
						res.cmd_valid  = 1'b1;
						res.cmd_kind   = st.pending_kind;
						case (st.pending_kind)
							KIND_NEW: st_nxt.game_started = 1'b1;
							KIND_RST: st_nxt.game_started = 1'b0;
							KIND_MOVE: begin
								res.cmd_row   = st.row_digit;
								res.cmd_col   = st.col_digit;
								res.cmd_value = st.value_digit;
							end
							default: begin
								res.cmd_row = st.row_digit;
								res.cmd_col = st.col_digit;
							end
						endcase
					end
					st_nxt.phase = PH_HASH;
				end
				default: begin
					// waiting for '#', unused codes behave the same
					if (rx_byte == CH_HASH) begin
						res.echo_valid   = 1'b1;
						st_nxt.digit_sum = 5'd0;
						st_nxt.phase     = PH_NRNUM;
					end else begin
						res.error_code = ERR_UNREC;
						st_nxt.phase   = PH_HASH;
					end
				end
			endcase
			res.echo_byte = res.echo_valid ? rx_byte : 8'd0;
		end
	end

endmodule

@@ design/ascii_command_parser_with_checksum.sv @@
// Top level of the ASCII command parser with checksum.
// Depends on acp_pkg, acp_step and assert_macros.svh.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid, in_stall | rx_byte, busy_req
//  out     | out_valid,out_stall| echo_valid, echo_byte, error_code, cmd_valid,
//          |                    | cmd_kind, cmd_row, cmd_col, cmd_value
//
// Flow: an item enters the input register, then one parse step moves it into
//   the result register; one item per cycle is sustained while out_stall is low.
// Parser state updates on the edge where the item leaves the input register.
// Reset (arst_n low) empties both registers and puts the parser in wait-for-'#'
//   with no game started.
// A stalled output holds the result register; in_stall rises only when the
//   input register is full and cannot drain.
`include "assert_macros.svh"

module ascii_command_parser_with_checksum (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       busy_req,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       echo_valid,
	output logic [7:0] echo_byte,
	output logic [1:0] error_code,
	output logic       cmd_valid,
	output logic [1:0] cmd_kind,
	output logic [3:0] cmd_row,
	output logic [3:0] cmd_col,
	output logic [3:0] cmd_value
);
	import acp_pkg::*;

	// input register
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       busy_s1;

	// parser state and result register
	state_t     st_q;
	state_t     st_nxt;
	result_t    res_nxt;
	result_t    res_q;
	logic       out_vld_q;

	logic       out_free;   // result register can load this cycle
	logic       adv;        // item in s1 moves to the result register
	logic       in_take;

	assign out_free = !out_vld_q || !out_stall;
	assign adv      = vld_s1 && out_free;
	assign in_stall = vld_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	acp_step u_step (
		.st       (st_q),
		.rx_byte  (byte_s1),
		.busy_req (busy_s1),
		.st_nxt   (st_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
			busy_s1 <= busy_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= STATE_RST;
			out_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				st_q <= st_nxt;
			end
			if (out_free) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid  = out_vld_q;
	assign echo_valid = res_q.echo_valid;
	assign echo_byte  = res_q.echo_byte;
	assign error_code = res_q.error_code;
	assign cmd_valid  = res_q.cmd_valid;
	assign cmd_kind   = res_q.cmd_kind;
	assign cmd_row    = res_q.cmd_row;
	assign cmd_col    = res_q.cmd_col;
	assign cmd_value  = res_q.cmd_value;

	// stall only when the input register is full and the output is blocked
	`ACP_ASSERT_IMP(a_stall_cause, in_stall, vld_s1 && out_vld_q && out_stall, "in_stall without full pipe")
	// a finished command is always echoed and error-free
	`ACP_ASSERT_IMP(a_cmd_echo, out_valid && cmd_valid, echo_valid && error_code == ERR_NONE, "command without echo")
	// an error never comes with an echo
	`ACP_ASSERT_IMP(a_err_no_echo, out_valid && error_code != ERR_NONE, !echo_valid && !cmd_valid, "echo on error")
	// every command (new, reset, move or candidate) ends in wait-for-'#'
	`ACP_ASSERT(a_cmd_phase, $past(adv && res_nxt.cmd_valid) |-> st_q.phase == PH_HASH, "phase after command")

endmodule
